@@ rtl/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// shared types and constants of the text console writer
// ----------------------------------------------------------------------------
package tcw_pkg;

    // fixed field widths
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int ROW_W      = 5;
    localparam int COL_W      = 7;
    localparam int OP_W       = 2;
    localparam int CURSOR_W   = 11;
    localparam int RD_LIN_W   = ROW_W + COL_W;

    // stream packing
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_PAD_W  = OUT_DATA_W - (CURSOR_W + CHAR_W + ATTR_W);
    localparam int IN_PAD_W   = IN_DATA_W - (CHAR_W + ROW_W + COL_W);

    // character codes and register reset
    localparam logic [CHAR_W-1:0] NEWLINE_CODE     = 8'd10;
    localparam logic [CHAR_W-1:0] NUL_CODE         = 8'd0;
    localparam logic [ATTR_W-1:0] CLEAR_ATTR_RESET = 8'h07;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PRINT = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    // sequencer states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_ROWCLR,
        ST_FILL,
        ST_READ,
        ST_FINISH
    } t_state;

    // one request as taken from the input stream
    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [CHAR_W-1:0] char_code;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_column;
    } t_request;

    // one result item
    typedef struct packed {
        logic                cursor_written;
        logic [CURSOR_W-1:0] cursor_position;
        logic [CHAR_W-1:0]   cell_char;
        logic [ATTR_W-1:0]   cell_attribute;
    } t_result;

endpackage

@@ rtl/tcw_ram.sv @@
// ----------------------------------------------------------------------------
// tcw_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/tcw_core.sv @@
// ----------------------------------------------------------------------------
// tcw_core
// sequencer of the console: write position, circular row base, clearing
// sweeps and the writes and reads of the cell memories
// ----------------------------------------------------------------------------
module tcw_core import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    localparam int CELLS  = ROWS * COLUMNS,
    localparam int ADDR_W = $clog2(CELLS),
    localparam int LIN_W  = $clog2(CELLS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_request          i_req,
    output logic              o_busy,
    input  logic [ATTR_W-1:0] i_clear_attr,
    input  logic              i_out_free,
    output logic              o_done,
    output t_result           o_result,
    output logic [ADDR_W-1:0] o_wr_addr,
    output logic              o_char_we,
    output logic [CHAR_W-1:0] o_char_wdata,
    output logic              o_attr_we,
    output logic [ATTR_W-1:0] o_attr_wdata,
    output logic [ADDR_W-1:0] o_rd_addr,
    input  logic [CHAR_W-1:0] i_rd_char,
    input  logic [ATTR_W-1:0] i_rd_attr
);

    localparam int SUM_W = LIN_W + 1;

    t_state              r_state, n_state;
    t_request            r_req, n_req;
    logic [ADDR_W-1:0]   r_rd_lin, n_rd_lin;
    logic                r_rd_ok, n_rd_ok;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [COL_W-1:0]    r_col, n_col;
    logic [LIN_W-1:0]    r_lin, n_lin;
    logic [CURSOR_W-1:0] r_cursor, n_cursor;
    logic [ADDR_W-1:0]   r_base_addr, n_base_addr;
    logic [ADDR_W-1:0]   r_sweep_addr, n_sweep_addr;
    logic [ADDR_W-1:0]   r_sweep_last, n_sweep_last;

    logic                w_ch_zero;
    logic                w_is_nl;
    logic                w_need_scroll;
    logic                w_col_last;
    logic                w_sweep_end;
    logic                w_exec_print;
    logic                w_print_char;
    logic                w_print_nl;
    logic                w_print_none;
    logic                w_in_rd_ok;
    logic [RD_LIN_W-1:0] w_in_rd_lin;
    logic [LIN_W-1:0]    w_lin_inc;

    // logical offset to physical address through the rotating row base
    function automatic logic [ADDR_W-1:0] f_wrap(input logic [ADDR_W-1:0] base,
                                                 input logic [LIN_W-1:0]  lin);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(lin);
        if (sum >= SUM_W'(CELLS)) begin
            sum = sum - SUM_W'(CELLS);
        end
        return ADDR_W'(sum);
    endfunction

    // request decode
    assign w_ch_zero     = (r_req.char_code == NUL_CODE);
    assign w_is_nl       = (r_req.char_code == NEWLINE_CODE);
    assign w_need_scroll = (r_row >= ROW_W'(ROWS));
    assign w_col_last    = (r_col == COL_W'(COLUMNS - 1));
    assign w_sweep_end   = (r_sweep_addr == r_sweep_last);
    assign w_exec_print  = (r_state == ST_EXEC) && (r_req.operation == OP_PRINT);
    assign w_print_char  = w_exec_print && !w_ch_zero && !w_need_scroll && !w_is_nl;
    assign w_print_nl    = w_exec_print && !w_ch_zero && !w_need_scroll && w_is_nl;
    assign w_print_none  = w_exec_print && w_ch_zero;
    assign w_lin_inc     = r_lin + LIN_W'(1);

    // read cell address of an incoming request
    assign w_in_rd_ok  = (i_req.read_row < ROW_W'(ROWS)) &&
                         ({1'b0, i_req.read_column} < (COL_W + 1)'(COLUMNS));
    assign w_in_rd_lin = RD_LIN_W'(i_req.read_row) * RD_LIN_W'(COLUMNS) +
                         RD_LIN_W'(i_req.read_column);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (w_sweep_end) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_start) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                unique case (r_req.operation)
                    OP_PRINT: begin
                        if (!w_ch_zero && w_need_scroll) begin
                            n_state = ST_ROWCLR;
                        end else if (i_out_free) begin
                            n_state = ST_IDLE;
                        end
                    end
                    OP_CLEAR: n_state = ST_FILL;
                    OP_READ:  n_state = ST_READ;
                    default: begin
                        if (i_out_free) n_state = ST_IDLE;
                    end
                endcase
            end
            ST_ROWCLR: begin
                if (w_sweep_end) n_state = ST_EXEC;
            end
            ST_FILL: begin
                if (w_sweep_end) n_state = ST_FINISH;
            end
            ST_READ, ST_FINISH: begin
                if (i_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_INIT;
        endcase
    end

    // outputs: memory ports and result
    always_comb begin
        o_busy                   = (r_state != ST_IDLE);
        o_wr_addr                = r_sweep_addr;
        o_char_we                = 1'b0;
        o_char_wdata             = NUL_CODE;
        o_attr_we                = 1'b0;
        o_attr_wdata             = i_clear_attr;
        o_rd_addr                = f_wrap(r_base_addr, LIN_W'(r_rd_lin));
        o_done                   = 1'b0;
        o_result.cursor_written  = 1'b0;
        o_result.cursor_position = r_cursor;
        o_result.cell_char       = '0;
        o_result.cell_attribute  = '0;
        unique case (r_state)
            ST_INIT: begin
                o_char_we    = 1'b1;
                o_attr_we    = 1'b1;
                o_attr_wdata = '0;
            end
            ST_ROWCLR, ST_FILL: begin
                o_char_we = 1'b1;
                o_attr_we = 1'b1;
            end
            ST_EXEC: begin
                if (w_print_char) begin
                    o_wr_addr    = f_wrap(r_base_addr, r_lin);
                    o_char_wdata = r_req.char_code;
                    o_char_we    = i_out_free;
                    o_done       = i_out_free;
                    o_result.cursor_written  = 1'b1;
                    o_result.cursor_position = CURSOR_W'(w_lin_inc);
                end else if (w_print_nl || w_print_none ||
                             ((r_req.operation != OP_PRINT) &&
                              (r_req.operation != OP_CLEAR) &&
                              (r_req.operation != OP_READ))) begin
                    o_done = i_out_free;
                end
            end
            ST_READ: begin
                o_done = i_out_free;
                if (r_rd_ok) begin
                    o_result.cell_char      = i_rd_char;
                    o_result.cell_attribute = i_rd_attr;
                end
            end
            ST_FINISH: begin
                o_done                  = i_out_free;
                o_result.cursor_written = 1'b1;
            end
            default: ;
        endcase
    end

    // datapath next values
    always_comb begin
        n_req        = r_req;
        n_rd_lin     = r_rd_lin;
        n_rd_ok      = r_rd_ok;
        n_row        = r_row;
        n_col        = r_col;
        n_lin        = r_lin;
        n_cursor     = r_cursor;
        n_base_addr  = r_base_addr;
        n_sweep_addr = r_sweep_addr;
        n_sweep_last = r_sweep_last;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_req    = i_req;
                    n_rd_ok  = w_in_rd_ok;
                    n_rd_lin = w_in_rd_ok ? ADDR_W'(w_in_rd_lin) : '0;
                end
            end
            ST_INIT, ST_ROWCLR, ST_FILL: begin
                n_sweep_addr = r_sweep_addr + ADDR_W'(1);
            end
            ST_EXEC: begin
                if (r_req.operation == OP_CLEAR) begin
                    // whole grid blank, everything home
                    n_sweep_addr = '0;
                    n_sweep_last = ADDR_W'(CELLS - 1);
                    n_base_addr  = '0;
                    n_row        = '0;
                    n_col        = '0;
                    n_lin        = '0;
                    n_cursor     = '0;
                end else if (w_exec_print && !w_ch_zero && w_need_scroll) begin
                    // scroll: old top row becomes the new bottom row
                    n_sweep_addr = r_base_addr;
                    n_sweep_last = r_base_addr + ADDR_W'(COLUMNS - 1);
                    n_base_addr  = (r_base_addr == ADDR_W'((ROWS - 1) * COLUMNS)) ?
                                   '0 : r_base_addr + ADDR_W'(COLUMNS);
                    n_row        = r_row - ROW_W'(1);
                    n_lin        = r_lin - LIN_W'(COLUMNS);
                end else if (w_print_nl && i_out_free) begin
                    n_row = r_row + ROW_W'(1);
                    n_col = '0;
                    n_lin = r_lin - LIN_W'(r_col) + LIN_W'(COLUMNS);
                end else if (w_print_char && i_out_free) begin
                    n_lin    = w_lin_inc;
                    n_cursor = CURSOR_W'(w_lin_inc);
                    if (w_col_last) begin
                        n_col = '0;
                        n_row = r_row + ROW_W'(1);
                    end else begin
                        n_col = r_col + COL_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_INIT;
            r_row        <= '0;
            r_col        <= '0;
            r_lin        <= '0;
            r_cursor     <= '0;
            r_base_addr  <= '0;
            r_sweep_addr <= '0;
            r_sweep_last <= ADDR_W'(CELLS - 1);
        end else begin
            r_state      <= n_state;
            r_row        <= n_row;
            r_col        <= n_col;
            r_lin        <= n_lin;
            r_cursor     <= n_cursor;
            r_base_addr  <= n_base_addr;
            r_sweep_addr <= n_sweep_addr;
            r_sweep_last <= n_sweep_last;
        end
    end

    // captured request
    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_rd_lin <= n_rd_lin;
        r_rd_ok  <= n_rd_ok;
    end

endmodule

@@ rtl/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_writer
// character-cell text console with scrolling, clear and cell read-back
// ----------------------------------------------------------------------------
// Every request gives exactly one result, in order. This account assumes the
// result port is free; while it is not, the block waits in the state that
// gives the result. A printed character, a newline, a string terminator or
// the spare operation code gives its result from ST_EXEC. The next request
// is taken once the block is back in ST_IDLE after giving that result. A
// character that finds the write row past the bottom scrolls first: the new
// bottom row is blanked one cell per cycle through the memory write port,
// then the character is handled (rows rotate through a base pointer, so no
// cells are moved). A cell read gives its result from ST_READ, after the
// registered memory read. A clear blanks all ROWS*COLUMNS cells one cell per
// cycle, then gives its result from ST_FINISH. After reset the block runs a
// clearing pass over all ROWS*COLUMNS cells with tready low; configuration
// writes are taken at all times. A new request is taken while the previous
// result still waits, and its own result then waits until that one has left.
module text_console_writer import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // char_code[7:0], read_row[12:8], read_column[19:13], zero[23:20]
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // operation[1:0]
    input  logic [OP_W-1:0]       i_s_axis_tuser,
    // result stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // cursor_position[10:0], cell_char[18:11], cell_attribute[26:19], zero[31:27]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // cursor_written[0]
    output logic [0:0]            o_m_axis_tuser,
    // clear attribute register
    input  logic                  i_cfg_wr_en,
    input  logic [ATTR_W-1:0]     i_cfg_wr_data
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);

    logic [ATTR_W-1:0] r_clear_attr;
    logic              r_out_valid;
    t_result           r_out;

    t_request          w_req;
    logic              w_start;
    logic              w_busy;
    logic              w_out_free;
    logic              w_done;
    t_result           w_result;
    logic [ADDR_W-1:0] w_wr_addr;
    logic              w_char_we;
    logic [CHAR_W-1:0] w_char_wdata;
    logic              w_attr_we;
    logic [ATTR_W-1:0] w_attr_wdata;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [CHAR_W-1:0] w_rd_char;
    logic [ATTR_W-1:0] w_rd_attr;

    // request unpacking and handshake
    assign w_req.operation   = i_s_axis_tuser;
    assign w_req.char_code   = i_s_axis_tdata[CHAR_W-1:0];
    assign w_req.read_row    = i_s_axis_tdata[CHAR_W +: ROW_W];
    assign w_req.read_column = i_s_axis_tdata[CHAR_W + ROW_W +: COL_W];
    assign o_s_axis_tready   = !w_busy;
    assign w_start           = i_s_axis_tvalid && !w_busy;
    assign w_out_free        = !r_out_valid || i_m_axis_tready;

    // clear attribute register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear_attr <= CLEAR_ATTR_RESET;
        end else if (i_cfg_wr_en) begin
            r_clear_attr <= i_cfg_wr_data;
        end
    end

    // sequencer
    tcw_core #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start),
        .i_req        (w_req),
        .o_busy       (w_busy),
        .i_clear_attr (r_clear_attr),
        .i_out_free   (w_out_free),
        .o_done       (w_done),
        .o_result     (w_result),
        .o_wr_addr    (w_wr_addr),
        .o_char_we    (w_char_we),
        .o_char_wdata (w_char_wdata),
        .o_attr_we    (w_attr_we),
        .o_attr_wdata (w_attr_wdata),
        .o_rd_addr    (w_rd_addr),
        .i_rd_char    (w_rd_char),
        .i_rd_attr    (w_rd_attr)
    );

    // character cells
    tcw_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CELLS)
    ) u_char_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_char_we),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_char_wdata),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_char)
    );

    // attribute cells
    tcw_ram #(
        .WIDTH (ATTR_W),
        .DEPTH (CELLS)
    ) u_attr_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_attr_we),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_attr_wdata),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_attr)
    );

    // result output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.cursor_written;
    assign o_m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out.cell_attribute,
                              r_out.cell_char, r_out.cursor_position};

endmodule

@@ rtl/tcw_checker.sv @@
// ----------------------------------------------------------------------------
// tcw_checker
// port-level assertions of the text console writer, bound to the top level
// ----------------------------------------------------------------------------
module tcw_checker import tcw_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_s_axis_tready,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic [0:0]            o_m_axis_tuser
);

    logic [CURSOR_W-1:0] r_last_cursor;

    // cursor seen in the last delivered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_cursor <= '0;
        end else if (o_m_axis_tvalid && i_m_axis_tready) begin
            r_last_cursor <= o_m_axis_tdata[CURSOR_W-1:0];
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // no request taken in the cycle after reset: clearing pass runs
    a_init_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready)
        else $error("request taken during clearing pass");

    // a cursor update never carries cell data
    a_written_no_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |->
            o_m_axis_tdata[CURSOR_W + CHAR_W + ATTR_W - 1:CURSOR_W] == '0)
        else $error("cell data on cursor update");

    // the cursor only moves on a result that reports it written
    a_cursor_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |->
            o_m_axis_tdata[CURSOR_W-1:0] == r_last_cursor)
        else $error("cursor moved without update");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);

@@ tb/sv/console_checker.sv @@
// ----------------------------------------------------------------------------
// console_checker
// watches the request and result streams of the text console writer, keeps
// its own copy of the cell grid, write position, cursor and clear attribute,
// works out the result of every accepted request and compares each accepted
// result field by field with the oldest one still awaited
// ----------------------------------------------------------------------------
module console_checker import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    input  logic                  i_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input  logic [OP_W-1:0]       i_s_axis_tuser,
    input  logic                  i_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    input  logic [OUT_DATA_W-1:0] i_m_axis_tdata,
    input  logic [0:0]            i_m_axis_tuser,
    input  logic                  i_cfg_wr_en,
    input  logic [ATTR_W-1:0]     i_cfg_wr_data,
    output int                    o_error_count,
    output int                    o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELLS = ROWS * COLUMNS;

    // shadow of the console state
    logic [CHAR_W-1:0]   glyph_grid [CELLS];
    logic [ATTR_W-1:0]   attr_grid  [CELLS];
    logic [ROW_W-1:0]    line_pos;
    logic [COL_W-1:0]    column_pos;
    logic [CURSOR_W-1:0] cursor_pos;
    logic [ATTR_W-1:0]   blank_attr;

    // results still to come, oldest first
    t_result console_results[$];
    t_result awaited;
    t_result produced;
    t_result observed;

    initial begin
        o_error_count = 0;
        o_outstanding = 0;
    end

    // blank one row with the current clear attribute
    function automatic void blank_row(int r);
        for (int c = 0; c < COLUMNS; c++) begin
            glyph_grid[r * COLUMNS + c] = NUL_CODE;
            attr_grid[r * COLUMNS + c]  = blank_attr;
        end
    endfunction

    // apply one request to the shadow state and build its result
    task automatic console_step(
        input  logic [OP_W-1:0]   op,
        input  logic [CHAR_W-1:0] ch,
        input  logic [ROW_W-1:0]  rd_row,
        input  logic [COL_W-1:0]  rd_col,
        output t_result           res
    );
        res = '0;
        case (op)
            OP_PRINT: begin
                if (ch != NUL_CODE) begin
                    // scroll when the write row has run past the bottom
                    if (line_pos >= ROWS) begin
                        for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
                            glyph_grid[i] = glyph_grid[i + COLUMNS];
                            attr_grid[i]  = attr_grid[i + COLUMNS];
                        end
                        blank_row(ROWS - 1);
                        line_pos = line_pos - 1'b1;
                    end
                    if (ch == NEWLINE_CODE) begin
                        line_pos   = line_pos + 1'b1;
                        column_pos = '0;
                    end else begin
                        if (line_pos < ROWS && column_pos < COLUMNS) begin
                            glyph_grid[line_pos * COLUMNS + column_pos] = ch;
                        end
                        // wrap at the line end, before the column can overflow
                        if (int'(column_pos) + 1 >= COLUMNS) begin
                            line_pos   = line_pos + 1'b1;
                            column_pos = '0;
                        end else begin
                            column_pos = column_pos + 1'b1;
                        end
                        cursor_pos = CURSOR_W'(line_pos * COLUMNS + column_pos);
                        res.cursor_written = 1'b1;
                    end
                end
            end
            OP_CLEAR: begin
                cursor_pos = '0;
                res.cursor_written = 1'b1;
                for (int r = 0; r < ROWS; r++) begin
                    blank_row(r);
                end
                line_pos   = '0;
                column_pos = '0;
            end
            OP_READ: begin
                if (rd_row < ROWS && rd_col < COLUMNS) begin
                    res.cell_char      = glyph_grid[rd_row * COLUMNS + rd_col];
                    res.cell_attribute = attr_grid[rd_row * COLUMNS + rd_col];
                end
            end
            default: begin
                // spare operation code leaves everything alone
            end
        endcase
        res.cursor_position = cursor_pos;
    endtask

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            o_error_count++;
        end
    endfunction

    // sample both streams and the register port at each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++) begin
                glyph_grid[i] = '0;
                attr_grid[i]  = '0;
            end
            line_pos   = '0;
            column_pos = '0;
            cursor_pos = '0;
            blank_attr = CLEAR_ATTR_RESET;
            console_results.delete();
        end else begin
            if (i_cfg_wr_en) begin
                blank_attr = i_cfg_wr_data;
            end

            // result side first: it always belongs to an earlier request
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                observed.cursor_written  = i_m_axis_tuser[0];
                observed.cursor_position = i_m_axis_tdata[CURSOR_W-1:0];
                observed.cell_char       = i_m_axis_tdata[CURSOR_W +: CHAR_W];
                observed.cell_attribute  = i_m_axis_tdata[CURSOR_W + CHAR_W +: ATTR_W];
                if (console_results.size() == 0) begin
                    $error("result with no request outstanding: tdata %h tuser %b",
                           i_m_axis_tdata, i_m_axis_tuser);
                    o_error_count++;
                end else begin
                    awaited = console_results.pop_front();
                    check_field("cursor_written", awaited.cursor_written,
                                observed.cursor_written);
                    check_field("cursor_position", awaited.cursor_position,
                                observed.cursor_position);
                    check_field("cell_char", awaited.cell_char, observed.cell_char);
                    check_field("cell_attribute", awaited.cell_attribute,
                                observed.cell_attribute);
                end
            end

            if (i_s_axis_tvalid && i_s_axis_tready) begin
                console_step(i_s_axis_tuser,
                             i_s_axis_tdata[CHAR_W-1:0],
                             i_s_axis_tdata[CHAR_W +: ROW_W],
                             i_s_axis_tdata[CHAR_W + ROW_W +: COL_W],
                             produced);
                console_results.push_back(produced);
            end
        end
        o_outstanding = console_results.size();
    end

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the text console writer: a short directed pass
// over field extremes and special requests, then phases of random text
// lines, newline runs, cell reads, clears and noise under several clear
// attribute settings, with random idling on both streams
// ----------------------------------------------------------------------------
module tb_top;
    import tcw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int PHASE_ITEMS  = 128;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 600;
    localparam int END_SETTLE   = 20;
    localparam int CYCLE_LIMIT  = 1_000_000;

    // operation code the block leaves unused
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [OP_W-1:0]       s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [ATTR_W-1:0]     cfg_wr_data = '0;

    int error_count;
    int outstanding;
    int cycle_count = 0;
    int requests_sent = 0;
    bit idle_on = 1'b1;

    always #5 clk = ~clk;

    text_console_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data)
    );

    console_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tuser  (m_tuser),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .o_error_count   (error_count),
        .o_outstanding   (outstanding)
    );

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off once HOLD_AFTER results are taken
    initial begin
        int  gap;
        int  taken;
        bit  got;
        bit  held;
        taken = 0;
        held  = 1'b0;
        @(posedge clk);
        forever begin
            gap = idle_on ? $urandom_range(0, 14) : 0;
            if (!held && taken >= HOLD_AFTER) begin
                held = 1'b1;
                gap  = HOLD_CYCLES;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do begin
                @(negedge clk);
                got = m_tvalid;
                @(posedge clk);
            end while (!got);
            taken++;
        end
    end

    // offer one request and return at the edge that takes it
    task automatic send_request(
        input logic [OP_W-1:0]   op,
        input logic [CHAR_W-1:0] ch,
        input logic [ROW_W-1:0]  row,
        input logic [COL_W-1:0]  col
    );
        int gap;
        bit taken;
        gap = idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{IN_PAD_W{1'b0}}, col, row, ch};
        do begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end while (!taken);
        requests_sent++;
    endtask

    // stop offering and wait until every result is back
    task automatic drain_results();
        bit busy;
        s_tvalid <= 1'b0;
        do begin
            @(negedge clk);
            busy = (outstanding != 0);
            @(posedge clk);
        end while (busy);
    endtask

    function automatic logic [ROW_W-1:0] any_row();
        return ROW_W'($urandom_range(0, (1 << ROW_W) - 1));
    endfunction

    function automatic logic [COL_W-1:0] any_col();
        return COL_W'($urandom_range(0, (1 << COL_W) - 1));
    endfunction

    // one random burst of related requests
    task automatic random_burst();
        int kind;
        int len;
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            // a line of text, long enough at times to wrap
            len = $urandom_range(1, 100);
            repeat (len) begin
                send_request(OP_PRINT, CHAR_W'($urandom_range(1, 255)), any_row(), any_col());
            end
            if ($urandom_range(0, 1)) begin
                send_request(OP_PRINT, NEWLINE_CODE, any_row(), any_col());
            end
        end else if (kind < 65) begin
            // newline run pushes the write row towards and past the bottom
            len = $urandom_range(1, 12);
            repeat (len) begin
                send_request(OP_PRINT, NEWLINE_CODE, any_row(), any_col());
            end
        end else if (kind < 85) begin
            // cell reads, mostly inside the grid
            len = $urandom_range(1, 6);
            repeat (len) begin
                if ($urandom_range(0, 7) == 0) begin
                    send_request(OP_READ, CHAR_W'($urandom), any_row(), any_col());
                end else begin
                    send_request(OP_READ, CHAR_W'($urandom),
                                 ROW_W'($urandom_range(0, ROWS - 1)),
                                 COL_W'($urandom_range(0, COLUMNS - 1)));
                end
            end
        end else if (kind < 97) begin
            // noise: string terminator or the spare operation code
            if ($urandom_range(0, 1)) begin
                send_request(OP_PRINT, NUL_CODE, any_row(), any_col());
            end else begin
                send_request(OP_SPARE, CHAR_W'($urandom), any_row(), any_col());
            end
        end else begin
            send_request(OP_CLEAR, CHAR_W'($urandom), any_row(), any_col());
        end
    endtask

    // reset, directed pass, random phases, verdict
    initial begin
        logic [ATTR_W-1:0] attr_setting;
        int                phase_start;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset contents, extremes, special requests
        send_request(OP_READ,  NUL_CODE, 5'd0,  7'd0);
        send_request(OP_PRINT, 8'h41,    5'd0,  7'd0);
        send_request(OP_PRINT, 8'hFF,    5'd31, 7'd127);
        send_request(OP_PRINT, 8'h01,    5'd0,  7'd0);
        send_request(OP_PRINT, NUL_CODE, 5'd0,  7'd0);
        send_request(OP_PRINT, NEWLINE_CODE, 5'd0, 7'd0);
        send_request(OP_READ,  NUL_CODE, 5'd0,  7'd0);
        send_request(OP_READ,  NUL_CODE, 5'd0,  7'd2);
        send_request(OP_READ,  NUL_CODE, 5'd24, 7'd79);
        send_request(OP_READ,  NUL_CODE, 5'd25, 7'd0);
        send_request(OP_READ,  NUL_CODE, 5'd0,  7'd80);
        send_request(OP_READ,  8'hFF,    5'd31, 7'd127);
        send_request(OP_SPARE, 8'hFF,    5'd31, 7'd127);
        send_request(OP_CLEAR, NUL_CODE, 5'd0,  7'd0);
        send_request(OP_READ,  NUL_CODE, 5'd24, 7'd79);
        send_request(OP_PRINT, NEWLINE_CODE, 5'd0, 7'd0);
        send_request(OP_PRINT, 8'h42,    5'd0,  7'd0);
        send_request(OP_READ,  NUL_CODE, 5'd1,  7'd0);

        // random phases, each under its own clear attribute
        for (int phase = 0; phase < 4; phase++) begin
            drain_results();
            repeat (4) @(posedge clk);
            case (phase)
                0:       attr_setting = 8'h00;
                1:       attr_setting = 8'hFF;
                default: attr_setting = ATTR_W'($urandom_range(1, 254));
            endcase
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= attr_setting;
            @(posedge clk);
            cfg_wr_en <= 1'b0;
            idle_on = (phase != 2);
            phase_start = requests_sent;
            send_request(OP_CLEAR, CHAR_W'($urandom), any_row(), any_col());
            while (requests_sent - phase_start < PHASE_ITEMS) begin
                random_burst();
            end
        end

        drain_results();
        repeat (END_SETTLE) @(posedge clk);
        if (error_count == 0 && outstanding == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ text_console_writer.f @@
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_core.sv
rtl/text_console_writer.sv
rtl/tcw_checker.sv
tb/sv/console_checker.sv
tb/sv/tb_top.sv
